[hdl/xst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xst_pkg
// Shared types, constants and character helpers of the XML stream tokenizer.
// ----------------------------------------------------------------------------
package xst_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int MAX_NAME  = 32;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int CUR_W     = $clog2(MAX_NAME + 1);
  localparam int DIDX_W    = $clog2(MAX_DEPTH);
  localparam int NIDX_W    = $clog2(MAX_NAME);
  localparam int STACK_W   = DIDX_W + NIDX_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [4:0] {
    P_START, P_PROLOG, P_CONTENT, P_LT, P_OPEN_NAME, P_SLASH, P_ATTR_START,
    P_ATTR_KEY, P_ATTR_KEY_SP, P_ATTR_EQ, P_ATTR_VALUE, P_ATTR_AFTER,
    P_CLOSE_FIRST, P_CLOSE_NAME, P_CLOSE_TAIL, P_BANG, P_COMMENT_OPEN,
    P_COMMENT, P_CDATA_OPEN, P_CDATA
  } phase_t;

  typedef enum logic [3:0] {
    EV_NAME, EV_START, EV_EMPTY, EV_CLOSE, EV_KEY, EV_VALUE, EV_ATTR,
    EV_TEXT, EV_CDATA, EV_ERROR, EV_END
  } ev_kind_t;

  typedef enum logic [2:0] {
    E_NONE, E_MALFORMED, E_UNCLOSED, E_MISMATCH, E_UNCLOSED_TAGS, E_OVERFLOW
  } err_kind_t;

  typedef struct packed {
    ev_kind_t     kind;
    logic [7:0]   data;
    logic [5:0]   depth;
    err_kind_t    err;
    logic [31:0]  pos;
  } ev_t;

  typedef struct packed {
    logic [1:0] cnt;
    ev_t        e0;
    ev_t        e1;
  } pair_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_name_start(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == ":";
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return is_name_start(b) || (b >= "0" && b <= "9") || b == "-" || b == ".";
  endfunction

  function automatic logic [7:0] prolog_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = "<";
      3'd1:    c = "?";
      3'd2:    c = "x";
      3'd3:    c = "m";
      default: c = "l";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cdata_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = "C";
      3'd1:    c = "D";
      3'd2:    c = "A";
      3'd3:    c = "T";
      3'd4:    c = "A";
      default: c = "[";
    endcase
    return c;
  endfunction

endpackage

[hdl/xst_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xst_front
// Byte classifier and scanner: updates scan state, name stack and depth, and
// produces up to two events per accepted byte.
// ----------------------------------------------------------------------------
module xst_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               is_final,
  input  logic               q_full,
  output logic               q_push,
  output xst_pkg::pair_t     q_data
);

  xst_pkg::phase_t phase, phase_next, ph_eff;
  logic        quote_dq, quote_dq_next;
  logic [1:0]  held, held_next;
  logic [2:0]  match_idx, match_idx_next;
  logic [31:0] pos, pos_next;
  logic [xst_pkg::DEPTH_W-1:0] depth, depth_next;
  logic [xst_pkg::CUR_W-1:0]   cursor, cursor_next, cur_eff;
  logic        mismatch, mismatch_next;
  logic        err_hold, err_hold_next;
  logic [7:0]  owed, owed_next;
  logic        owed_vld, owed_vld_next;

  logic [7:0] stack_mem [xst_pkg::MAX_DEPTH * xst_pkg::MAX_NAME];
  logic [xst_pkg::CUR_W-1:0] lens [xst_pkg::MAX_DEPTH];
  logic [7:0] stack_rd;

  logic        stk_we, len_we, failed;
  logic [xst_pkg::STACK_W-1:0] stk_waddr, stk_raddr;
  logic [xst_pkg::DIDX_W-1:0]  top_idx;
  logic [xst_pkg::CUR_W-1:0]   top_len;
  logic [xst_pkg::DEPTH_W-1:0] depth_m1_next;
  xst_pkg::pair_t pr;
  logic [7:0] b;
  logic       acc;

  function automatic xst_pkg::pair_t push(input xst_pkg::pair_t p, input xst_pkg::ev_kind_t k,
                                          input logic [7:0] d, input xst_pkg::err_kind_t e,
                                          input logic [31:0] ps);
    xst_pkg::pair_t r;
    xst_pkg::ev_t   ev;
    r        = p;
    ev.kind  = k;
    ev.data  = d;
    ev.depth = '0;
    ev.err   = e;
    ev.pos   = ps;
    if (p.cnt == 2'd0) begin
      r.e0  = ev;
      r.cnt = 2'd1;
    end else if (p.cnt == 2'd1) begin
      r.e1  = ev;
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  function automatic xst_pkg::pair_t fail_ev(input xst_pkg::err_kind_t e, input logic [31:0] ps);
    xst_pkg::pair_t r;
    r     = '0;
    r     = push(r, xst_pkg::EV_ERROR, 8'd0, e, ps);
    return r;
  endfunction

  assign b        = data_byte;
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign top_idx  = xst_pkg::DIDX_W'(depth - xst_pkg::DEPTH_W'(1));
  assign top_len  = lens[top_idx];
  assign depth_m1_next = depth_next - xst_pkg::DEPTH_W'(1);
  assign stk_raddr = {depth_m1_next[xst_pkg::DIDX_W-1:0], cursor_next[xst_pkg::NIDX_W-1:0]};
  assign stk_waddr = {depth[xst_pkg::DIDX_W-1:0], cur_eff[xst_pkg::NIDX_W-1:0]};

  always_comb begin
    phase_next     = phase;
    quote_dq_next  = quote_dq;
    held_next      = held;
    match_idx_next = match_idx;
    pos_next       = pos;
    depth_next     = depth;
    cursor_next    = cursor;
    mismatch_next  = mismatch;
    err_hold_next  = err_hold;
    owed_next      = owed;
    owed_vld_next  = owed_vld;
    pr             = '0;
    failed         = 1'b0;
    stk_we         = 1'b0;
    len_we         = 1'b0;
    cur_eff        = cursor;
    ph_eff         = phase;

    if (err_hold) begin
      pos_next = pos + 32'd1;
    end else begin
      if (phase == xst_pkg::P_START && b != xst_pkg::prolog_char(match_idx)) begin
        if (match_idx == 3'd0) begin
          ph_eff = xst_pkg::P_CONTENT;
        end else if (match_idx == 3'd1) begin
          ph_eff         = xst_pkg::P_LT;
          match_idx_next = 3'd0;
        end
      end

      unique case (ph_eff)
        xst_pkg::P_START: begin
          if (b == xst_pkg::prolog_char(match_idx)) begin
            match_idx_next = match_idx + 3'd1;
            if (match_idx == 3'd4) begin
              phase_next     = xst_pkg::P_PROLOG;
              held_next      = 2'd0;
              match_idx_next = 3'd0;
            end
          end else begin
            match_idx_next = 3'd0;
            pr     = fail_ev(xst_pkg::E_MALFORMED, 32'd1);
            failed = 1'b1;
          end
        end
        xst_pkg::P_PROLOG: begin
          if (held == 2'd1 && b == ">") begin
            phase_next = xst_pkg::P_CONTENT;
            held_next  = 2'd0;
          end else begin
            held_next = (b == "?") ? 2'd1 : 2'd0;
          end
        end
        xst_pkg::P_CONTENT: begin
          phase_next = xst_pkg::P_CONTENT;
          if (b == "<") begin
            phase_next = xst_pkg::P_LT;
          end else if (b == "&" || b == ">" || b == 8'h22 || b == 8'h27) begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end else begin
            pr = push(pr, xst_pkg::EV_TEXT, b, xst_pkg::E_NONE, pos);
          end
        end
        xst_pkg::P_LT: begin
          phase_next = xst_pkg::P_LT;
          if (b == "/") begin
            phase_next    = xst_pkg::P_CLOSE_FIRST;
            cursor_next   = '0;
            mismatch_next = 1'b0;
          end else if (b == "!") begin
            phase_next = xst_pkg::P_BANG;
          end else if (xst_pkg::is_name_start(b)) begin
            phase_next  = xst_pkg::P_OPEN_NAME;
            cur_eff     = '0;
            stk_we      = (depth < xst_pkg::DEPTH_W'(xst_pkg::MAX_DEPTH));
            cursor_next = xst_pkg::CUR_W'(1);
            pr = push(pr, xst_pkg::EV_NAME, b, xst_pkg::E_NONE, pos);
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_OPEN_NAME: begin
          if (b == "/") begin
            phase_next = xst_pkg::P_SLASH;
          end else if (b == ">") begin
            if (depth >= xst_pkg::DEPTH_W'(xst_pkg::MAX_DEPTH)) begin
              pr     = fail_ev(xst_pkg::E_OVERFLOW, pos);
              failed = 1'b1;
            end else begin
              len_we     = 1'b1;
              depth_next = depth + xst_pkg::DEPTH_W'(1);
              phase_next = xst_pkg::P_CONTENT;
              pr = push(pr, xst_pkg::EV_START, 8'd0, xst_pkg::E_NONE, pos);
            end
          end else if (xst_pkg::is_name_char(b)) begin
            if (cursor >= xst_pkg::CUR_W'(xst_pkg::MAX_NAME)) begin
              pr     = fail_ev(xst_pkg::E_OVERFLOW, pos);
              failed = 1'b1;
            end else begin
              stk_we      = (depth < xst_pkg::DEPTH_W'(xst_pkg::MAX_DEPTH));
              cursor_next = cursor + xst_pkg::CUR_W'(1);
              pr = push(pr, xst_pkg::EV_NAME, b, xst_pkg::E_NONE, pos);
            end
          end else if (xst_pkg::is_space(b)) begin
            phase_next = xst_pkg::P_ATTR_START;
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_SLASH: begin
          if (b == ">") begin
            phase_next = xst_pkg::P_CONTENT;
            pr = push(pr, xst_pkg::EV_EMPTY, 8'd0, xst_pkg::E_NONE, pos);
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos - 32'd1);
            failed = 1'b1;
          end
        end
        xst_pkg::P_ATTR_START, xst_pkg::P_ATTR_AFTER: begin
          if (xst_pkg::is_space(b)) begin
            phase_next = xst_pkg::P_ATTR_START;
          end else if (b == "/") begin
            phase_next = xst_pkg::P_SLASH;
          end else if (b == ">") begin
            if (depth >= xst_pkg::DEPTH_W'(xst_pkg::MAX_DEPTH)) begin
              pr     = fail_ev(xst_pkg::E_OVERFLOW, pos);
              failed = 1'b1;
            end else begin
              len_we     = 1'b1;
              depth_next = depth + xst_pkg::DEPTH_W'(1);
              phase_next = xst_pkg::P_CONTENT;
              pr = push(pr, xst_pkg::EV_START, 8'd0, xst_pkg::E_NONE, pos);
            end
          end else if (phase == xst_pkg::P_ATTR_START && xst_pkg::is_name_start(b)) begin
            phase_next = xst_pkg::P_ATTR_KEY;
            pr = push(pr, xst_pkg::EV_KEY, b, xst_pkg::E_NONE, pos);
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_ATTR_KEY: begin
          if (b == "=") begin
            phase_next = xst_pkg::P_ATTR_EQ;
          end else if (xst_pkg::is_name_char(b)) begin
            pr = push(pr, xst_pkg::EV_KEY, b, xst_pkg::E_NONE, pos);
          end else if (xst_pkg::is_space(b)) begin
            phase_next = xst_pkg::P_ATTR_KEY_SP;
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_ATTR_KEY_SP: begin
          if (b == "=") begin
            phase_next = xst_pkg::P_ATTR_EQ;
          end else if (!xst_pkg::is_space(b)) begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_ATTR_EQ: begin
          if (b == 8'h22 || b == 8'h27) begin
            quote_dq_next = (b == 8'h22);
            phase_next    = xst_pkg::P_ATTR_VALUE;
          end else if (!xst_pkg::is_space(b)) begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_ATTR_VALUE: begin
          if (b == (quote_dq ? 8'h22 : 8'h27)) begin
            phase_next = xst_pkg::P_ATTR_AFTER;
            pr = push(pr, xst_pkg::EV_ATTR, 8'd0, xst_pkg::E_NONE, pos);
          end else begin
            pr = push(pr, xst_pkg::EV_VALUE, b, xst_pkg::E_NONE, pos);
          end
        end
        xst_pkg::P_CLOSE_FIRST, xst_pkg::P_CLOSE_NAME: begin
          if ((phase == xst_pkg::P_CLOSE_FIRST && xst_pkg::is_name_start(b)) ||
              (phase == xst_pkg::P_CLOSE_NAME && xst_pkg::is_name_char(b))) begin
            phase_next = xst_pkg::P_CLOSE_NAME;
            if (depth == '0 || cursor >= top_len || stack_rd != b) begin
              mismatch_next = 1'b1;
            end
            if (cursor < xst_pkg::CUR_W'(xst_pkg::MAX_NAME)) begin
              cursor_next = cursor + xst_pkg::CUR_W'(1);
            end
          end else if (phase == xst_pkg::P_CLOSE_NAME && xst_pkg::is_space(b)) begin
            phase_next = xst_pkg::P_CLOSE_TAIL;
          end else if (phase == xst_pkg::P_CLOSE_NAME && b == ">") begin
            if (mismatch || depth == '0 || cursor != top_len) begin
              pr     = fail_ev(xst_pkg::E_MISMATCH, pos);
              failed = 1'b1;
            end else begin
              depth_next = depth - xst_pkg::DEPTH_W'(1);
              phase_next = xst_pkg::P_CONTENT;
              pr = push(pr, xst_pkg::EV_CLOSE, 8'd0, xst_pkg::E_NONE, pos);
            end
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_CLOSE_TAIL: begin
          if (b == ">") begin
            if (mismatch || depth == '0 || cursor != top_len) begin
              pr     = fail_ev(xst_pkg::E_MISMATCH, pos);
              failed = 1'b1;
            end else begin
              depth_next = depth - xst_pkg::DEPTH_W'(1);
              phase_next = xst_pkg::P_CONTENT;
              pr = push(pr, xst_pkg::EV_CLOSE, 8'd0, xst_pkg::E_NONE, pos);
            end
          end else if (!xst_pkg::is_space(b)) begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_BANG: begin
          if (b == "[") begin
            phase_next     = xst_pkg::P_CDATA_OPEN;
            match_idx_next = 3'd0;
          end else if (b == "-") begin
            phase_next = xst_pkg::P_COMMENT_OPEN;
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_COMMENT_OPEN: begin
          if (b == "-") begin
            phase_next = xst_pkg::P_COMMENT;
            held_next  = 2'd0;
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos - 32'd1);
            failed = 1'b1;
          end
        end
        xst_pkg::P_COMMENT: begin
          if (b == "-") begin
            if (held != 2'd3) begin
              held_next = held + 2'd1;
            end
          end else if (b == ">" && held >= 2'd2) begin
            if (held == 2'd3) begin
              pr     = fail_ev(xst_pkg::E_MALFORMED, pos - 32'd3);
              failed = 1'b1;
            end else begin
              phase_next = xst_pkg::P_CONTENT;
              held_next  = 2'd0;
            end
          end else begin
            held_next = 2'd0;
          end
        end
        xst_pkg::P_CDATA_OPEN: begin
          if (match_idx < 3'd6 && b == xst_pkg::cdata_char(match_idx)) begin
            match_idx_next = match_idx + 3'd1;
            if (match_idx == 3'd5) begin
              phase_next     = xst_pkg::P_CDATA;
              held_next      = 2'd0;
              match_idx_next = 3'd0;
            end
          end else begin
            pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
            failed = 1'b1;
          end
        end
        xst_pkg::P_CDATA: begin
          if (owed_vld) begin
            pr = push(pr, xst_pkg::EV_CDATA, owed, xst_pkg::E_NONE, pos - 32'd1);
            owed_vld_next = 1'b0;
          end
          if (b == "]") begin
            if (held < 2'd2) begin
              held_next = held + 2'd1;
            end else begin
              pr = push(pr, xst_pkg::EV_CDATA, 8'h5D, xst_pkg::E_NONE, pos - 32'd2);
            end
          end else if (b == ">" && held == 2'd2) begin
            held_next  = 2'd0;
            phase_next = xst_pkg::P_CONTENT;
          end else begin
            if (held == 2'd0) begin
              pr = push(pr, xst_pkg::EV_CDATA, b, xst_pkg::E_NONE, pos);
            end else if (held == 2'd1) begin
              pr = push(pr, xst_pkg::EV_CDATA, 8'h5D, xst_pkg::E_NONE, pos - 32'd1);
              pr = push(pr, xst_pkg::EV_CDATA, b, xst_pkg::E_NONE, pos);
            end else begin
              pr = push(pr, xst_pkg::EV_CDATA, 8'h5D, xst_pkg::E_NONE, pos - 32'd2);
              pr = push(pr, xst_pkg::EV_CDATA, 8'h5D, xst_pkg::E_NONE, pos - 32'd1);
              owed_next     = b;
              owed_vld_next = 1'b1;
            end
            held_next = 2'd0;
          end
        end
        default: begin
          pr     = fail_ev(xst_pkg::E_MALFORMED, pos);
          failed = 1'b1;
        end
      endcase

      if (!failed && is_final) begin
        priority case (phase_next)
          xst_pkg::P_CONTENT: begin
            if (depth_next != '0) begin
              pr = fail_ev(xst_pkg::E_UNCLOSED_TAGS, pos);
            end else begin
              pr = push(pr, xst_pkg::EV_END, 8'd0, xst_pkg::E_NONE, pos);
            end
          end
          xst_pkg::P_START: pr = fail_ev(xst_pkg::E_MALFORMED, 32'd1);
          xst_pkg::P_PROLOG, xst_pkg::P_COMMENT, xst_pkg::P_CDATA:
            pr = fail_ev(xst_pkg::E_UNCLOSED, pos + 32'd1);
          default: pr = fail_ev(xst_pkg::E_MALFORMED, pos + 32'd1);
        endcase
        failed = (pr.e0.kind == xst_pkg::EV_ERROR);
      end

      pr.e0.depth = 6'(depth_next);
      pr.e1.depth = 6'(depth_next);
      pos_next    = pos + 32'd1;
      if (failed) begin
        err_hold_next = 1'b1;
      end
    end

    if (is_final) begin
      phase_next     = xst_pkg::P_START;
      quote_dq_next  = 1'b0;
      held_next      = 2'd0;
      match_idx_next = 3'd0;
      pos_next       = '0;
      depth_next     = '0;
      cursor_next    = '0;
      mismatch_next  = 1'b0;
      err_hold_next  = 1'b0;
      owed_vld_next  = 1'b0;
    end
  end

  assign q_push = acc && (pr.cnt != 2'd0);
  assign q_data = pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= xst_pkg::P_START;
      quote_dq  <= 1'b0;
      held      <= 2'd0;
      match_idx <= 3'd0;
      pos       <= '0;
      depth     <= '0;
      cursor    <= '0;
      mismatch  <= 1'b0;
      err_hold  <= 1'b0;
      owed_vld  <= 1'b0;
    end else if (acc) begin
      phase     <= phase_next;
      quote_dq  <= quote_dq_next;
      held      <= held_next;
      match_idx <= match_idx_next;
      pos       <= pos_next;
      depth     <= depth_next;
      cursor    <= cursor_next;
      mismatch  <= mismatch_next;
      err_hold  <= err_hold_next;
      owed_vld  <= owed_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      owed <= owed_next;
      if (stk_we) begin
        stack_mem[stk_waddr] <= b;
      end
      if (len_we) begin
        lens[depth[xst_pkg::DIDX_W-1:0]] <= cursor;
      end
      stack_rd <= stack_mem[stk_raddr];
    end
  end

endmodule

[hdl/xst_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xst_queue
// Short FIFO of event pairs between scanner and output stage.
// ----------------------------------------------------------------------------
module xst_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  xst_pkg::pair_t wdata,
  input  logic           pop,
  output xst_pkg::pair_t head,
  output logic           full,
  output logic           empty
);

  xst_pkg::pair_t mem [xst_pkg::QDEPTH];
  logic [xst_pkg::QPTR_W-1:0] wptr, rptr;
  logic [xst_pkg::QPTR_W:0]   count;

  assign full  = (count == (xst_pkg::QPTR_W + 1)'(xst_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + xst_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + xst_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (xst_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (xst_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

[hdl/xst_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xst_back
// Output stage: splits queued event pairs into single transactions.
// ----------------------------------------------------------------------------
module xst_back (
  input  logic           clk,
  input  logic           rst,
  input  xst_pkg::pair_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     event_kind,
  output logic [7:0]     event_byte,
  output logic [5:0]     nesting_depth,
  output logic [2:0]     error_kind,
  output logic [31:0]    byte_position,
  output logic           last_of_run
);

  logic        second;
  logic        load;
  xst_pkg::ev_t sel;

  assign load = !out_valid || !out_stall;
  assign sel  = second ? head.e1 : head.e0;
  assign pop  = load && !empty && (second || head.cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        second <= !second && (head.cnt == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      event_kind    <= sel.kind;
      event_byte    <= sel.data;
      nesting_depth <= sel.depth;
      error_kind    <= sel.err;
      byte_position <= sel.pos;
      last_of_run   <= second || head.cnt == 2'd1;
    end
  end

endmodule

[hdl/xml_stream_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_stream_tokenizer
// Byte-serial XML tokenizer with name-stack tag matching.
// ----------------------------------------------------------------------------
// Input channel: data_byte and is_final with in_valid / in_stall; one document
// byte per transaction, is_final on the last byte of a document.
// Output channel: one event per transaction with out_valid / out_stall;
// last_of_run marks the last event caused by a byte.
// Throughput: one byte per cycle while the event queue is not full; a byte
// that yields two events is absorbed by the four-entry event queue.
// Each byte's events pass through the event queue and the output register.
// The scanner stalls only when the event queue is full; a stalled output
// holds its event, and the queue keeps filling behind it.
// Reset clears scan state, depth, position and the queue; name storage is
// not cleared. A final byte returns the scanner to the document start.
// ----------------------------------------------------------------------------
module xml_stream_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_kind,
  output logic [7:0]  event_byte,
  output logic [5:0]  nesting_depth,
  output logic [2:0]  error_kind,
  output logic [31:0] byte_position,
  output logic        last_of_run
);

  logic           q_full, q_empty, q_push, q_pop;
  xst_pkg::pair_t q_wdata, q_head;

  xst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .is_final  (is_final),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  xst_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  xst_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .event_byte    (event_byte),
    .nesting_depth (nesting_depth),
    .error_kind    (error_kind),
    .byte_position (byte_position),
    .last_of_run   (last_of_run)
  );

endmodule

[test/xml_stream_tokenizer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_stream_tokenizer_checker
// Event predictor and scoreboard for the XML stream tokenizer.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted document byte is run through a local
// tokenizer model that yields the expected events. Each accepted event is
// compared field by field with the oldest expected event.
// ----------------------------------------------------------------------------
module xml_stream_tokenizer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_final,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  event_kind,
  input  logic [7:0]  event_byte,
  input  logic [5:0]  nesting_depth,
  input  logic [2:0]  error_kind,
  input  logic [31:0] byte_position,
  input  logic        last_of_run,
  output int          failures,
  output int          pending,
  output int          events_seen,
  output int          errors_seen
);

  typedef struct {
    xst_pkg::ev_kind_t  kind;
    logic [7:0]         data;
    logic [5:0]         depth;
    xst_pkg::err_kind_t err;
    logic [31:0]        pos;
    logic               last;
  } token_event_t;

  token_event_t expected_events[$];
  token_event_t step_ev[2];
  int           step_n;
  bit           step_fail;

  xst_pkg::phase_t phase;
  bit           quote_dbl;
  int           held;
  int           match_idx;
  logic [31:0]  pos_count;
  int           depth;
  logic [7:0]   names[xst_pkg::MAX_DEPTH * xst_pkg::MAX_NAME];
  int           name_len[xst_pkg::MAX_DEPTH];
  int           cursor;
  bit           close_bad;
  bit           hold_err;
  logic [7:0]   owed;
  bit           owed_ok;

  function automatic bit space_char(logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit name_lead(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == ":";
  endfunction

  function automatic bit name_body(logic [7:0] b);
    return name_lead(b) || (b >= "0" && b <= "9") || b == "-" || b == ".";
  endfunction

  function automatic logic [7:0] prolog_at(int i);
    string w;
    w = "<?xml";
    return w[i];
  endfunction

  function automatic logic [7:0] cdata_at(int i);
    string w;
    w = "CDATA[";
    return w[i];
  endfunction

  task clear_state();
    phase = xst_pkg::P_START;
    quote_dbl = 0;
    held = 0;
    match_idx = 0;
    pos_count = 0;
    depth = 0;
    cursor = 0;
    close_bad = 0;
    hold_err = 0;
    owed = 0;
    owed_ok = 0;
  endtask

  task add_event(xst_pkg::ev_kind_t k, logic [7:0] d, xst_pkg::err_kind_t e, logic [31:0] p);
    if (step_n < 2) begin
      step_ev[step_n] = '{k, d, depth[5:0], e, p, 1'b0};
      step_n++;
    end
  endtask

  task raise_error(xst_pkg::err_kind_t e, logic [31:0] p);
    step_n = 0;
    add_event(xst_pkg::EV_ERROR, 8'd0, e, p);
    step_fail = 1;
  endtask

  task name_byte(logic [7:0] b, logic [31:0] p);
    if (cursor >= xst_pkg::MAX_NAME) begin
      raise_error(xst_pkg::E_OVERFLOW, p);
    end else begin
      if (depth < xst_pkg::MAX_DEPTH) names[depth * xst_pkg::MAX_NAME + cursor] = b;
      cursor++;
      add_event(xst_pkg::EV_NAME, b, xst_pkg::E_NONE, p);
    end
  endtask

  task finish_start(logic [31:0] p);
    if (depth >= xst_pkg::MAX_DEPTH) begin
      raise_error(xst_pkg::E_OVERFLOW, p);
    end else begin
      name_len[depth] = cursor;
      depth++;
      phase = xst_pkg::P_CONTENT;
      add_event(xst_pkg::EV_START, 8'd0, xst_pkg::E_NONE, p);
    end
  endtask

  task close_name_byte(logic [7:0] b);
    if (depth == 0 || depth > xst_pkg::MAX_DEPTH) close_bad = 1;
    else if (cursor >= name_len[depth - 1]) close_bad = 1;
    else if (names[(depth - 1) * xst_pkg::MAX_NAME + cursor] != b) close_bad = 1;
    if (cursor < xst_pkg::MAX_NAME) cursor++;
  endtask

  task finish_close(logic [31:0] p);
    if (close_bad || depth == 0 || depth > xst_pkg::MAX_DEPTH) begin
      raise_error(xst_pkg::E_MISMATCH, p);
    end else if (cursor != name_len[depth - 1]) begin
      raise_error(xst_pkg::E_MISMATCH, p);
    end else begin
      depth--;
      phase = xst_pkg::P_CONTENT;
      add_event(xst_pkg::EV_CLOSE, 8'd0, xst_pkg::E_NONE, p);
    end
  endtask

  task text_byte(logic [7:0] b, logic [31:0] p);
    if (b == "<") phase = xst_pkg::P_LT;
    else if (b == "&" || b == ">" || b == "\"" || b == "'")
      raise_error(xst_pkg::E_MALFORMED, p);
    else add_event(xst_pkg::EV_TEXT, b, xst_pkg::E_NONE, p);
  endtask

  task after_lt(logic [7:0] b, logic [31:0] p);
    if (b == "/") begin
      phase = xst_pkg::P_CLOSE_FIRST;
      cursor = 0;
      close_bad = 0;
    end else if (b == "!") begin
      phase = xst_pkg::P_BANG;
    end else if (name_lead(b)) begin
      cursor = 0;
      phase = xst_pkg::P_OPEN_NAME;
      name_byte(b, p);
    end else begin
      raise_error(xst_pkg::E_MALFORMED, p);
    end
  endtask

  task cdata_byte(logic [7:0] b, logic [31:0] p);
    if (owed_ok) begin
      add_event(xst_pkg::EV_CDATA, owed, xst_pkg::E_NONE, p - 1);
      owed_ok = 0;
    end
    if (b == "]") begin
      if (held < 2) held++;
      else add_event(xst_pkg::EV_CDATA, "]", xst_pkg::E_NONE, p - 2);
    end else if (b == ">" && held == 2) begin
      held = 0;
      phase = xst_pkg::P_CONTENT;
    end else begin
      if (held == 0) begin
        add_event(xst_pkg::EV_CDATA, b, xst_pkg::E_NONE, p);
      end else if (held == 1) begin
        add_event(xst_pkg::EV_CDATA, "]", xst_pkg::E_NONE, p - 1);
        add_event(xst_pkg::EV_CDATA, b, xst_pkg::E_NONE, p);
      end else begin
        add_event(xst_pkg::EV_CDATA, "]", xst_pkg::E_NONE, p - 2);
        add_event(xst_pkg::EV_CDATA, "]", xst_pkg::E_NONE, p - 1);
        owed = b;
        owed_ok = 1;
      end
      held = 0;
    end
  endtask

  task scan_byte(logic [7:0] b, logic [31:0] p);
    case (phase)
      xst_pkg::P_START: begin
        if (match_idx < 5 && b == prolog_at(match_idx)) begin
          match_idx++;
          if (match_idx == 5) begin
            phase = xst_pkg::P_PROLOG;
            held = 0;
            match_idx = 0;
          end
        end else if (match_idx == 0) begin
          phase = xst_pkg::P_CONTENT;
          text_byte(b, p);
        end else if (match_idx == 1) begin
          match_idx = 0;
          phase = xst_pkg::P_LT;
          after_lt(b, p);
        end else begin
          match_idx = 0;
          raise_error(xst_pkg::E_MALFORMED, 32'd1);
        end
      end
      xst_pkg::P_PROLOG: begin
        if (held == 1 && b == ">") begin
          phase = xst_pkg::P_CONTENT;
          held = 0;
        end else begin
          held = (b == "?") ? 1 : 0;
        end
      end
      xst_pkg::P_CONTENT: text_byte(b, p);
      xst_pkg::P_LT: after_lt(b, p);
      xst_pkg::P_OPEN_NAME: begin
        if (b == "/") phase = xst_pkg::P_SLASH;
        else if (b == ">") finish_start(p);
        else if (name_body(b)) name_byte(b, p);
        else if (space_char(b)) phase = xst_pkg::P_ATTR_START;
        else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_SLASH: begin
        if (b == ">") begin
          phase = xst_pkg::P_CONTENT;
          add_event(xst_pkg::EV_EMPTY, 8'd0, xst_pkg::E_NONE, p);
        end else begin
          raise_error(xst_pkg::E_MALFORMED, p - 1);
        end
      end
      xst_pkg::P_ATTR_START, xst_pkg::P_ATTR_AFTER: begin
        if (space_char(b)) phase = xst_pkg::P_ATTR_START;
        else if (b == "/") phase = xst_pkg::P_SLASH;
        else if (b == ">") finish_start(p);
        else if (phase == xst_pkg::P_ATTR_START && name_lead(b)) begin
          phase = xst_pkg::P_ATTR_KEY;
          add_event(xst_pkg::EV_KEY, b, xst_pkg::E_NONE, p);
        end else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_ATTR_KEY: begin
        if (b == "=") phase = xst_pkg::P_ATTR_EQ;
        else if (name_body(b)) add_event(xst_pkg::EV_KEY, b, xst_pkg::E_NONE, p);
        else if (space_char(b)) phase = xst_pkg::P_ATTR_KEY_SP;
        else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_ATTR_KEY_SP: begin
        if (b == "=") phase = xst_pkg::P_ATTR_EQ;
        else if (!space_char(b)) raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_ATTR_EQ: begin
        if (b == "\"" || b == "'") begin
          quote_dbl = (b == "\"");
          phase = xst_pkg::P_ATTR_VALUE;
        end else if (!space_char(b)) raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_ATTR_VALUE: begin
        if (b == (quote_dbl ? 8'h22 : 8'h27)) begin
          phase = xst_pkg::P_ATTR_AFTER;
          add_event(xst_pkg::EV_ATTR, 8'd0, xst_pkg::E_NONE, p);
        end else add_event(xst_pkg::EV_VALUE, b, xst_pkg::E_NONE, p);
      end
      xst_pkg::P_CLOSE_FIRST: begin
        if (name_lead(b)) begin
          close_name_byte(b);
          phase = xst_pkg::P_CLOSE_NAME;
        end else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_CLOSE_NAME: begin
        if (name_body(b)) close_name_byte(b);
        else if (space_char(b)) phase = xst_pkg::P_CLOSE_TAIL;
        else if (b == ">") finish_close(p);
        else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_CLOSE_TAIL: begin
        if (b == ">") finish_close(p);
        else if (!space_char(b)) raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_BANG: begin
        if (b == "[") begin
          phase = xst_pkg::P_CDATA_OPEN;
          match_idx = 0;
        end else if (b == "-") phase = xst_pkg::P_COMMENT_OPEN;
        else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_COMMENT_OPEN: begin
        if (b == "-") begin
          phase = xst_pkg::P_COMMENT;
          held = 0;
        end else raise_error(xst_pkg::E_MALFORMED, p - 1);
      end
      xst_pkg::P_COMMENT: begin
        if (b == "-") begin
          if (held < 3) held++;
        end else if (b == ">" && held >= 2) begin
          if (held == 3) raise_error(xst_pkg::E_MALFORMED, p - 3);
          else begin
            phase = xst_pkg::P_CONTENT;
            held = 0;
          end
        end else held = 0;
      end
      xst_pkg::P_CDATA_OPEN: begin
        if (match_idx < 6 && b == cdata_at(match_idx)) begin
          match_idx++;
          if (match_idx == 6) begin
            phase = xst_pkg::P_CDATA;
            held = 0;
            match_idx = 0;
          end
        end else raise_error(xst_pkg::E_MALFORMED, p);
      end
      xst_pkg::P_CDATA: cdata_byte(b, p);
      default: raise_error(xst_pkg::E_MALFORMED, p);
    endcase
  endtask

  task predict_events(logic [7:0] b, logic fin);
    logic [31:0] p;
    p = pos_count;
    step_n = 0;
    step_fail = 0;
    if (hold_err) begin
      if (fin) clear_state();
      else pos_count++;
    end else begin
      scan_byte(b, p);
      if (!step_fail && fin) begin
        case (phase)
          xst_pkg::P_CONTENT: begin
            if (depth > 0) raise_error(xst_pkg::E_UNCLOSED_TAGS, p);
            else add_event(xst_pkg::EV_END, 8'd0, xst_pkg::E_NONE, p);
          end
          xst_pkg::P_START: raise_error(xst_pkg::E_MALFORMED, 32'd1);
          xst_pkg::P_PROLOG, xst_pkg::P_COMMENT, xst_pkg::P_CDATA:
            raise_error(xst_pkg::E_UNCLOSED, p + 1);
          default: raise_error(xst_pkg::E_MALFORMED, p + 1);
        endcase
      end
      if (step_n > 0) step_ev[step_n - 1].last = 1;
      for (int i = 0; i < step_n; i++)
        expected_events.insert(expected_events.size(), step_ev[i]);
      if (fin) clear_state();
      else begin
        if (step_fail) hold_err = 1;
        pos_count++;
      end
    end
  endtask

  task report(string what, logic [31:0] got, logic [31:0] want);
    failures++;
    if (failures <= 30)
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  initial begin
    failures = 0;
    events_seen = 0;
    errors_seen = 0;
    clear_state();
  end

  always @(posedge clk) begin
    token_event_t want;
    if (rst) begin
      expected_events.delete();
      clear_state();
    end else begin
      if (in_valid && !in_stall) predict_events(data_byte, is_final);
      if (out_valid && !out_stall) begin
        events_seen++;
        if (event_kind == xst_pkg::EV_ERROR) errors_seen++;
        if (expected_events.size() == 0) begin
          report("unexpected event, kind", 32'(event_kind), 32'd0);
        end else begin
          want = expected_events.pop_front();
          if (event_kind != want.kind)
            report("event_kind", 32'(event_kind), 32'(want.kind));
          if (event_byte != want.data)
            report("event_byte", 32'(event_byte), 32'(want.data));
          if (nesting_depth != want.depth)
            report("nesting_depth", 32'(nesting_depth), 32'(want.depth));
          if (error_kind != want.err)
            report("error_kind", 32'(error_kind), 32'(want.err));
          if (byte_position != want.pos) report("byte_position", byte_position, want.pos);
          if (last_of_run != want.last)
            report("last_of_run", 32'(last_of_run), 32'(want.last));
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

[test/xml_stream_tokenizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_stream_tokenizer_test
// Top-level testbench of the XML stream tokenizer.
// ----------------------------------------------------------------------------
// Feeds directed corner-case documents, then randomly generated, mostly
// well-formed documents with occasional corruption, plus byte noise. The sender
// runs in bursts with gaps, the receiver stalls on a changing pattern, and the
// checker instance predicts and compares every event.
// ----------------------------------------------------------------------------
module xml_stream_tokenizer_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_BYTES = 1400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        is_final;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  event_kind;
  logic [7:0]  event_byte;
  logic [5:0]  nesting_depth;
  logic [2:0]  error_kind;
  logic [31:0] byte_position;
  logic        last_of_run;

  int          failures;
  int          pending;
  int          events_seen;
  int          errors_seen;
  int          cycles;
  int          bytes_sent;
  int          docs_sent;
  int          burst_left;
  int          stall_mode;
  logic [7:0]  doc[$];

  xml_stream_tokenizer uut (.*);

  xml_stream_tokenizer_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst <= 1;
    in_valid <= 0;
    data_byte <= 0;
    is_final <= 0;
    out_stall <= 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("xml_stream_tokenizer: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycles[2];
    endcase
  end

  task push_text(string s);
    for (int i = 0; i < s.len(); i++) doc.insert(doc.size(), s[i]);
  endtask

  function automatic string random_name(int len);
    string lead;
    string body;
    string s;
    lead = "abAB_:";
    body = "abAB_:09-.";
    s = "";
    for (int i = 0; i < len; i++) begin
      if (i == 0) s = {s, string'(lead[$urandom_range(0, lead.len() - 1)])};
      else s = {s, string'(body[$urandom_range(0, body.len() - 1)])};
    end
    return s;
  endfunction

  function automatic string random_from(string pool, int len);
    string s;
    s = "";
    for (int i = 0; i < len; i++) s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
    return s;
  endfunction

  task send_byte(logic [7:0] b, logic fin);
    if (burst_left == 0) burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
    in_valid <= 1;
    data_byte <= b;
    is_final <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task send_doc();
    for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
    docs_sent++;
    doc.delete();
  endtask

  task drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task directed_doc(string s);
    push_text(s);
    send_doc();
  endtask

  // mostly well-formed document with random content (tags may be left open), optionally corrupted
  task build_random_doc();
    string open_names[$];
    string nm;
    int n;
    int k;
    if ($urandom_range(0, 2) == 0) push_text("<?xml version=\"1.0\"?>");
    n = $urandom_range(2, 14);
    for (int t = 0; t < n; t++) begin
      k = $urandom_range(0, 9);
      if (k <= 2 && open_names.size() < 34) begin
        nm = random_name(($urandom_range(0, 19) == 0) ? $urandom_range(30, 33)
                                                     : $urandom_range(1, 4));
        push_text({"<", nm});
        repeat ($urandom_range(0, 2)) begin
          push_text({random_from(" \t", $urandom_range(1, 2)), random_name($urandom_range(1, 3)),
                     random_from(" ", $urandom_range(0, 1)), "="});
          if ($urandom_range(0, 1)) push_text({"\"", random_from("ab >'/", $urandom_range(0, 4)), "\""});
          else push_text({"'", random_from("ab >\"", $urandom_range(0, 4)), "'"});
        end
        if ($urandom_range(0, 4) == 0) push_text("/>");
        else begin
          push_text(">");
          open_names.insert(open_names.size(), nm);
        end
      end else if (k == 3 && open_names.size() > 0) begin
        nm = open_names[open_names.size() - 1];
        open_names.delete(open_names.size() - 1);
        push_text({"</", nm, random_from(" ", $urandom_range(0, 2)), ">"});
      end else if (k == 6) begin
        push_text({"<!--", random_from("-a b", $urandom_range(0, 5)), "-->"});
      end else if (k == 7) begin
        push_text({"<![CDATA[", random_from("]]a>x", $urandom_range(0, 6)), "]]>"});
      end else begin
        push_text(random_from("ab c\n1;=", $urandom_range(1, 5)));
      end
    end
    if ($urandom_range(0, 4) != 0)
      while (open_names.size() > 0) begin
        nm = open_names[open_names.size() - 1];
        open_names.delete(open_names.size() - 1);
        push_text({"</", nm, ">"});
      end
    if (doc.size() == 0) push_text("x");
    k = $urandom_range(0, 19);
    if (k < 3) doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
    else if (k == 3 && doc.size() > 1) doc = doc[0:$urandom_range(0, doc.size() - 2)];
  endtask

  initial begin
    cycles = 0;
    bytes_sent = 0;
    docs_sent = 0;
    burst_left = 0;
    stall_mode = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed_doc("<?xml v?><a x=\"1>\" y = 'q'>t<![CDATA[a]]x]]]>]]></a  >");
    directed_doc("<!----><b/>");
    directed_doc("<!-- a --->");
    directed_doc("<?x");
    directed_doc("<?q");
    directed_doc("<x");
    directed_doc("<a/b>");
    directed_doc("</a>");
    directed_doc("<a></b>");
    directed_doc("<ab></a b>");
    directed_doc("&");
    directed_doc("<a>");
    directed_doc("<!-- x");
    directed_doc("<![CDATA[x");
    directed_doc("<!x");
    directed_doc("<!-x");
    directed_doc("<![CDAXA[");
    directed_doc("<a =");
    directed_doc("<_:aZ09-.>\t</_:aZ09-.>");
    directed_doc({"<", random_name(32), "/>"});
    directed_doc({"<", random_name(33), ">"});
    repeat (33) push_text("<a>");
    send_doc();
    doc.insert(doc.size(), 8'h00);
    doc.insert(doc.size(), 8'hff);
    send_doc();
    drain();

    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 8)) doc.insert(doc.size(), 8'($urandom_range(0, 255)));
      end else begin
        build_random_doc();
      end
      send_doc();
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d bytes in %0d documents", bytes_sent, docs_sent);
    $display("checked %0d events, %0d of them errors", events_seen, errors_seen);
    if (failures == 0 && pending == 0) begin
      $display("xml_stream_tokenizer: match");
    end else begin
      $display("xml_stream_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hdl/xst_pkg.sv
hdl/xst_front.sv
hdl/xst_queue.sv
hdl/xst_back.sv
hdl/xml_stream_tokenizer.sv
test/xml_stream_tokenizer_checker.sv
test/xml_stream_tokenizer_test.sv
